@@ design/mt19937_random_generator_unit_defines.svh @@
// Assertion macros used by the checker file of the generator.
// Depends on nothing; the including scope provides clk and rst_n.
`ifndef MT19937_RANDOM_GENERATOR_UNIT_DEFINES_SVH
`define MT19937_RANDOM_GENERATOR_UNIT_DEFINES_SVH

// Check a property outside of reset.
`define MTRG_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Check a property at every edge, reset included.
`define MTRG_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ design/mtrg_pkg.sv @@
// Shared types, constants and the output tempering function of the generator.
// No dependencies.
`timescale 1ns / 1ps

package mtrg_pkg;

  localparam int SDEPTH   = 624;
  localparam int SADDR_W  = 10;
  localparam int TW_SHIFT = 397;

  localparam int IN_TDATA_W  = 72;
  localparam int OUT_TDATA_W = 32;

  localparam logic [1:0] FUNC_DRAW = 2'd0;
  localparam logic [1:0] FUNC_SEED = 2'd1;
  localparam logic [1:0] FUNC_KEY  = 2'd2;

  localparam logic [SADDR_W-1:0] LAST_POS     = SADDR_W'(SDEPTH - 1);
  localparam logic [SADDR_W-1:0] IDX_FULL     = SADDR_W'(SDEPTH);
  localparam logic [SADDR_W-1:0] IDX_UNSEEDED = SADDR_W'(SDEPTH + 1);

  localparam logic [31:0] TWIST_MAT   = 32'h9908_b0df;
  localparam logic [31:0] HI_BIT      = 32'h8000_0000;
  localparam logic [31:0] LIN_MULT    = 32'd1812433253;
  localparam logic [31:0] ARR_MULT1   = 32'd1664525;
  localparam logic [31:0] ARR_MULT2   = 32'd1566083941;
  localparam logic [31:0] TEMPER_B    = 32'h9d2c_5680;
  localparam logic [31:0] TEMPER_C    = 32'hefc6_0000;
  localparam logic [31:0] ARR_SEED    = 32'd19650218;
  localparam logic [31:0] DFLT_SEED   = 32'd5489;

  // Raw state word handed to the output stage.
  typedef struct packed {
    logic        valid;
    logic [31:0] word;
  } mtrg_word_t;

  function automatic logic [31:0] temper(input logic [31:0] w);
    logic [31:0] y;
    y = w ^ (w >> 11);
    y = y ^ ((y << 7) & TEMPER_B);
    y = y ^ ((y << 15) & TEMPER_C);
    y = y ^ (y >> 18);
    return y;
  endfunction

endpackage

@@ design/mtrg_ram.sv @@
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module mtrg_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    // hold read data until the next read
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ design/mtrg_out.sv @@
// Output stage: tempers a raw state word and holds it on the result channel.
// Depends on mtrg_pkg.
`timescale 1ns / 1ps

module mtrg_out import mtrg_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  mtrg_word_t             load,
  output logic                   can_load,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata   // [31:0] random_word
);

  logic        out_valid_r, out_valid_nxt;
  logic [31:0] out_data_r;
  logic        take;

  assign can_load      = !out_valid_r || out_tready;
  assign take          = load.valid && can_load;
  assign out_valid_nxt = take || (out_valid_r && !out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
    if (take) begin
      out_data_r <= temper(load.word);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

@@ design/mt19937_random_generator_unit.sv @@
// 32-bit MT19937 generator around a 624-word state RAM with one read and one write port.
// A draw word reads one state word and hands it to the output stage, waiting while that
// stage is full; every 624th draw first runs the twist pass, which for each state word
// reads the next word and the word 397 ahead. A seed word runs the linear recurrence
// through one registered 32x32 multiplier and the RAM write. A draw before any
// seeding runs that seeding from default_seed and then the twist.
// A key word is stored in the key buffer; the word with tlast set also runs the array
// seeding (linear seeding, then two sweeps over the state words).
// Up to KEY_DEPTH key words are kept; more are dropped. The result channel has its
// own register, so a finished word may wait there while the next word is accepted.
// Depends on mtrg_pkg, mtrg_ram and mtrg_out.
`timescale 1ns / 1ps

module mt19937_random_generator_unit import mtrg_pkg::*; #(
  parameter int KEY_DEPTH = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // [1:0] func, [33:2] seed_value, [65:34] key_word, [71:66] zero
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  input  logic                   in_tlast,   // key_last
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // [31:0] random_word
  output logic [OUT_TDATA_W-1:0] out_tdata,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [31:0]            cfg_data    // default_seed
);

  localparam int KIDX_W = (KEY_DEPTH > 1) ? $clog2(KEY_DEPTH) : 1;
  localparam int KCNT_W = $clog2(KEY_DEPTH + 1);
  localparam int KCMP_W = KCNT_W + 1;

  typedef enum logic [3:0] {
    ST_IDLE, ST_LS_W0, ST_LS_MUL, ST_LS_WR, ST_AS_MUL, ST_AS_WR, ST_AS_WRAP,
    ST_AS_FINAL, ST_TW_START, ST_TW_HI, ST_TW_LO, ST_TW_WR, ST_DRAW_RD, ST_DRAW_OUT
  } state_t;

  typedef enum logic [1:0] {
    AFTER_IDLE, AFTER_TWIST, AFTER_ARRAY
  } after_t;

  state_t              state_r, state_nxt;
  after_t              mode_r, mode_nxt;
  logic [SADDR_W-1:0]  idx_r, idx_nxt;
  logic [SADDR_W-1:0]  pos_r, pos_nxt;
  logic [SADDR_W-1:0]  cnt_r, cnt_nxt;
  logic                phase2_r, phase2_nxt;
  logic                hi_r, hi_nxt;
  logic [31:0]         prev_r, prev_nxt;
  logic [31:0]         prod_r, prod_nxt;
  logic [31:0]         y_r, y_nxt;
  logic [31:0]         dseed_r, dseed_nxt;
  logic [KIDX_W-1:0]   kb_r, kb_nxt;
  logic [KCNT_W-1:0]   kcount_r, kcount_nxt;
  logic [KCNT_W-1:0]   klen_r, klen_nxt;

  logic [1:0]          in_func;
  logic [31:0]         in_seed;
  logic [31:0]         in_key;
  logic                in_acc;
  logic                key_full;

  logic                ram_we, ram_re;
  logic [SADDR_W-1:0]  ram_waddr, ram_raddr;
  logic [31:0]         ram_wdata, ram_rdata;
  logic                key_we, key_re;
  logic [KIDX_W-1:0]   key_waddr;
  logic [31:0]         key_rdata;

  logic [31:0]         mul_x, mul_k, mul_lo;
  logic [31:0]         ls_val, as_val, tw_val;
  logic [SADDR_W:0]    far_sum, near_sum;
  logic [SADDR_W-1:0]  tw_far, tw_near;
  logic [KCMP_W-1:0]   kb_inc;
  mtrg_word_t          draw_load;
  logic                can_load;

  assign in_func   = in_tdata[1:0];
  assign in_seed   = in_tdata[33:2];
  assign in_key    = in_tdata[65:34];
  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;
  assign dseed_nxt = cfg_valid ? cfg_data : dseed_r;
  assign key_full  = (kcount_r == KCNT_W'(KEY_DEPTH));

  // shared multiplier, registered into prod_r
  assign mul_x  = prev_r ^ (prev_r >> 30);
  assign mul_k  = (state_r == ST_LS_MUL) ? LIN_MULT : (phase2_r ? ARR_MULT2 : ARR_MULT1);
  assign mul_lo = mul_x * mul_k;

  assign ls_val = prod_r + 32'(pos_r);
  assign as_val = phase2_r ? ((ram_rdata ^ prod_r) - 32'(pos_r))
                           : ((ram_rdata ^ prod_r) + key_rdata + 32'(kb_r));
  assign tw_val = ram_rdata ^ (y_r >> 1) ^ (y_r[0] ? TWIST_MAT : 32'd0);

  // wrap word addresses around the state depth
  assign far_sum  = {1'b0, pos_r} + (SADDR_W + 1)'(TW_SHIFT);
  assign tw_far   = (far_sum >= (SADDR_W + 1)'(SDEPTH)) ?
                    SADDR_W'(far_sum - (SADDR_W + 1)'(SDEPTH)) : far_sum[SADDR_W-1:0];
  assign near_sum = {1'b0, pos_r} + (SADDR_W + 1)'(2);
  assign tw_near  = (near_sum >= (SADDR_W + 1)'(SDEPTH)) ?
                    SADDR_W'(near_sum - (SADDR_W + 1)'(SDEPTH)) : near_sum[SADDR_W-1:0];

  assign kb_inc    = KCMP_W'(kb_r) + KCMP_W'(1);
  assign key_waddr = kcount_r[KIDX_W-1:0];

  always_comb begin
    state_nxt  = state_r;
    mode_nxt   = mode_r;
    idx_nxt    = idx_r;
    pos_nxt    = pos_r;
    cnt_nxt    = cnt_r;
    phase2_nxt = phase2_r;
    hi_nxt     = hi_r;
    prev_nxt   = prev_r;
    prod_nxt   = prod_r;
    y_nxt      = y_r;
    kb_nxt     = kb_r;
    kcount_nxt = kcount_r;
    klen_nxt   = klen_r;
    ram_we     = 1'b0;
    ram_waddr  = pos_r;
    ram_wdata  = ls_val;
    ram_re     = 1'b0;
    ram_raddr  = pos_r;
    key_we     = 1'b0;
    key_re     = 1'b0;
    draw_load  = '0;

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          case (in_func)
            FUNC_DRAW: begin
              if (idx_r == IDX_UNSEEDED) begin
                prev_nxt  = dseed_r;
                mode_nxt  = AFTER_TWIST;
                state_nxt = ST_LS_W0;
              end else if (idx_r == IDX_FULL) begin
                state_nxt = ST_TW_START;
              end else begin
                ram_re    = 1'b1;
                ram_raddr = idx_r;
                state_nxt = ST_DRAW_OUT;
              end
            end
            FUNC_SEED: begin
              prev_nxt  = in_seed;
              mode_nxt  = AFTER_IDLE;
              state_nxt = ST_LS_W0;
            end
            FUNC_KEY: begin
              // drop the word once the buffer is full
              if (!key_full) begin
                key_we     = 1'b1;
                kcount_nxt = kcount_r + KCNT_W'(1);
              end
              if (in_tlast) begin
                klen_nxt   = key_full ? kcount_r : kcount_r + KCNT_W'(1);
                kcount_nxt = '0;
                prev_nxt   = ARR_SEED;
                mode_nxt   = AFTER_ARRAY;
                state_nxt  = ST_LS_W0;
              end
            end
            default: ;
          endcase
        end
      end
      ST_LS_W0: begin
        ram_we    = 1'b1;
        ram_waddr = '0;
        ram_wdata = prev_r;
        pos_nxt   = SADDR_W'(1);
        state_nxt = ST_LS_MUL;
      end
      ST_LS_MUL: begin
        prod_nxt  = mul_lo;
        state_nxt = ST_LS_WR;
      end
      ST_LS_WR: begin
        ram_we   = 1'b1;
        prev_nxt = ls_val;
        if (pos_r == LAST_POS) begin
          idx_nxt = IDX_FULL;
          case (mode_r)
            AFTER_TWIST: state_nxt = ST_TW_START;
            AFTER_ARRAY: begin
              prev_nxt   = ARR_SEED;
              pos_nxt    = SADDR_W'(1);
              kb_nxt     = '0;
              cnt_nxt    = IDX_FULL;
              phase2_nxt = 1'b0;
              state_nxt  = ST_AS_MUL;
            end
            default: state_nxt = ST_IDLE;
          endcase
        end else begin
          pos_nxt   = pos_r + SADDR_W'(1);
          state_nxt = ST_LS_MUL;
        end
      end
      ST_AS_MUL: begin
        ram_re    = 1'b1;
        key_re    = 1'b1;
        prod_nxt  = mul_lo;
        state_nxt = ST_AS_WR;
      end
      ST_AS_WR: begin
        ram_we    = 1'b1;
        ram_wdata = as_val;
        prev_nxt  = as_val;
        kb_nxt    = (kb_inc >= KCMP_W'(klen_r)) ? '0 : kb_inc[KIDX_W-1:0];
        if (cnt_r == SADDR_W'(1) && phase2_r) begin
          // word 0 is overwritten at the end, so skip the wrap copy
          state_nxt = ST_AS_FINAL;
        end else begin
          if (cnt_r == SADDR_W'(1)) begin
            phase2_nxt = 1'b1;
            cnt_nxt    = LAST_POS;
          end else begin
            cnt_nxt = cnt_r - SADDR_W'(1);
          end
          if (pos_r == LAST_POS) begin
            pos_nxt   = SADDR_W'(1);
            state_nxt = ST_AS_WRAP;
          end else begin
            pos_nxt   = pos_r + SADDR_W'(1);
            state_nxt = ST_AS_MUL;
          end
        end
      end
      ST_AS_WRAP: begin
        ram_we    = 1'b1;
        ram_waddr = '0;
        ram_wdata = prev_r;
        state_nxt = ST_AS_MUL;
      end
      ST_AS_FINAL: begin
        ram_we    = 1'b1;
        ram_waddr = '0;
        ram_wdata = HI_BIT;
        idx_nxt   = IDX_FULL;
        state_nxt = ST_IDLE;
      end
      ST_TW_START: begin
        ram_re    = 1'b1;
        ram_raddr = '0;
        pos_nxt   = '0;
        state_nxt = ST_TW_HI;
      end
      ST_TW_HI: begin
        hi_nxt    = ram_rdata[31];
        ram_re    = 1'b1;
        ram_raddr = SADDR_W'(1);
        state_nxt = ST_TW_LO;
      end
      ST_TW_LO: begin
        // the word just read is also the next step's own word: keep its top bit
        y_nxt     = {hi_r, ram_rdata[30:0]};
        hi_nxt    = ram_rdata[31];
        ram_re    = 1'b1;
        ram_raddr = tw_far;
        state_nxt = ST_TW_WR;
      end
      ST_TW_WR: begin
        ram_we    = 1'b1;
        ram_wdata = tw_val;
        if (pos_r == LAST_POS) begin
          idx_nxt   = '0;
          state_nxt = ST_DRAW_RD;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = tw_near;
          pos_nxt   = pos_r + SADDR_W'(1);
          state_nxt = ST_TW_LO;
        end
      end
      ST_DRAW_RD: begin
        ram_re    = 1'b1;
        ram_raddr = idx_r;
        state_nxt = ST_DRAW_OUT;
      end
      ST_DRAW_OUT: begin
        draw_load.valid = 1'b1;
        draw_load.word  = ram_rdata;
        if (can_load) begin
          idx_nxt   = idx_r + SADDR_W'(1);
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      mode_r   <= AFTER_IDLE;
      idx_r    <= IDX_UNSEEDED;
      phase2_r <= 1'b0;
      kcount_r <= '0;
      dseed_r  <= DFLT_SEED;
    end else begin
      state_r  <= state_nxt;
      mode_r   <= mode_nxt;
      idx_r    <= idx_nxt;
      phase2_r <= phase2_nxt;
      kcount_r <= kcount_nxt;
      dseed_r  <= dseed_nxt;
    end
    pos_r  <= pos_nxt;
    cnt_r  <= cnt_nxt;
    hi_r   <= hi_nxt;
    prev_r <= prev_nxt;
    prod_r <= prod_nxt;
    y_r    <= y_nxt;
    kb_r   <= kb_nxt;
    klen_r <= klen_nxt;
  end

  mtrg_ram #(
    .WIDTH (32),
    .DEPTH (SDEPTH)
  ) u_state_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  mtrg_ram #(
    .WIDTH (32),
    .DEPTH (KEY_DEPTH)
  ) u_key_ram (
    .clk   (clk),
    .we    (key_we),
    .waddr (key_waddr),
    .wdata (in_key),
    .re    (key_re),
    .raddr (kb_r),
    .rdata (key_rdata)
  );

  mtrg_out u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (draw_load),
    .can_load   (can_load),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

@@ design/mtrg_checker.sv @@
// Port-level checks of the generator, attached to the top level by bind.
// Depends on mtrg_pkg and mt19937_random_generator_unit_defines.svh.
`timescale 1ns / 1ps
`include "mt19937_random_generator_unit_defines.svh"

module mtrg_checker import mtrg_pkg::*; (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_tvalid,
  input logic                  in_tready,
  input logic [IN_TDATA_W-1:0] in_tdata,
  input logic                  out_tvalid,
  input logic                  out_tready
);

  logic in_acc;
  assign in_acc = in_tvalid && in_tready;

  `MTRG_ASSERT(a_out_hold, out_tvalid && !out_tready |=> out_tvalid, "result word dropped")
  `MTRG_ASSERT(a_busy_after_draw_seed, in_acc && (in_tdata[1:0] == FUNC_DRAW || in_tdata[1:0] == FUNC_SEED) |=> !in_tready, "input still ready after draw or seed")
  `MTRG_ASSERT(a_no_result_from_other, in_acc && in_tdata[1:0] != FUNC_DRAW && !out_tvalid |=> !out_tvalid, "result from a non-draw word")
  `MTRG_ASSERT(a_result_while_busy, $rose(out_tvalid) |-> !$past(in_tready), "result appeared while idle")
  `MTRG_ASSERT_ALWAYS(a_reset_clears_out, !rst_n |=> !out_tvalid, "result valid after reset")

endmodule

bind mt19937_random_generator_unit mtrg_checker u_mtrg_checker (.*);
